// File: sv/pae_pkg.sv
`timescale 1ns / 1ps

package pae_pkg;

  localparam int SYM_W     = 4;
  localparam int ST_W      = 4;
  localparam int DEPTH_W   = 6;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = MASK_W;

  // Table and stack geometry, tied to the field widths above
  localparam int STATE_COUNT     = 16;
  localparam int SLOTS_PER_STATE = 8;
  localparam int STACK_SIZE      = 32;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_END    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EV_MOVE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2,
    EV_STUCK  = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_STATE = 1'd0,
    CFG_ACCEPT_MASK = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ST_W-1:0]  entry_state;
    logic [2:0]       entry_slot;
    logic             entry_valid;
    logic [SYM_W-1:0] entry_read;
    logic [SYM_W-1:0] entry_pop;
    logic [SYM_W-1:0] entry_push;
    logic [ST_W-1:0]  entry_next;
    logic [SYM_W-1:0] symbol;
  } pae_in_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [ST_W-1:0]    from_state;
    logic [SYM_W-1:0]   read_sym;
    logic [SYM_W-1:0]   pop_sym;
    logic [SYM_W-1:0]   push_sym;
    logic [ST_W-1:0]    to_state;
    logic [DEPTH_W-1:0] depth;
    logic [SYM_W-1:0]   top_sym;
    logic               last;
  } pae_out_t;

  // One transition slot as stored in the table memory
  typedef struct packed {
    logic [SYM_W-1:0] rd_sym;
    logic [SYM_W-1:0] pop_sym;
    logic [SYM_W-1:0] push_sym;
    logic [ST_W-1:0]  nxt;
  } pae_slot_t;

  typedef struct packed {
    logic      valid;
    pae_slot_t slot;
  } pae_entry_t;

  // Stack command from the sequencer
  typedef struct packed {
    logic             clear;
    logic             apply;
    logic [SYM_W-1:0] pop_sym;
    logic [SYM_W-1:0] push_sym;
  } pae_stack_op_t;

endpackage

// File: sv/pae_if.sv
`timescale 1ns / 1ps

interface pae_in_if;
  import pae_pkg::*;
  logic    valid;
  logic    ready;
  pae_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pae_out_if;
  import pae_pkg::*;
  logic     valid;
  logic     ready;
  pae_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/pae_table.sv
`timescale 1ns / 1ps

module pae_table #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  pae_pkg::pae_entry_t   wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output pae_pkg::pae_entry_t   rd_data_o
);
  import pae_pkg::*;

  pae_slot_t        mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  pae_slot_t        slot_q;
  logic             vld_q;

  // Write slot contents and read registered
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i.slot;
    end
    if (rd_en_i) begin
      slot_q <= mem[rd_addr_i];
    end
  end

  // Hold per-slot valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= wr_data_i.valid;
      end
      if (rd_en_i) begin
        vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o.valid = vld_q;
  assign rd_data_o.slot  = slot_q;

endmodule

// File: sv/pae_stack.sv
`timescale 1ns / 1ps

module pae_stack #(
  parameter int DEPTH = 32,
  parameter int CW    = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pae_pkg::pae_stack_op_t     op_i,
  output logic [CW-1:0]              count_o,
  output logic [pae_pkg::SYM_W-1:0]  top_o,
  output logic                       overflow_o
);
  import pae_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SYM_W-1:0] mem [DEPTH];
  logic [SYM_W-1:0] rd_q;
  logic [SYM_W-1:0] top_q;
  logic [CW-1:0]    count_q;
  logic             refill_q;
  logic [CW-1:0]    cnt_pop;
  logic [CW-1:0]    cnt_dec;
  logic             popped;
  logic             do_push;
  logic             do_refill;

  // Pop first, then check room for the push
  assign popped     = (op_i.pop_sym != '0) && (count_q != '0);
  assign cnt_pop    = popped ? count_q - CW'(1) : count_q;
  assign cnt_dec    = cnt_pop - CW'(1);
  assign overflow_o = (op_i.push_sym != '0) && (cnt_pop >= CW'(DEPTH));
  assign do_push    = op_i.apply && !op_i.clear && (op_i.push_sym != '0) && !overflow_o;
  assign do_refill  = op_i.apply && !op_i.clear && (op_i.push_sym == '0) && popped
                      && (cnt_pop != '0);

  // Write pushed symbol, fetch the new top after a bare pop
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[cnt_pop[AW-1:0]] <= op_i.push_sym;
    end
    if (do_refill) begin
      rd_q <= mem[cnt_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      top_q    <= '0;
      refill_q <= 1'b0;
    end else begin
      if (refill_q) begin
        top_q <= rd_q;
      end
      refill_q <= 1'b0;
      if (op_i.clear) begin
        count_q <= '0;
        top_q   <= '0;
      end else if (do_push) begin
        count_q <= cnt_pop + CW'(1);
        top_q   <= op_i.push_sym;
      end else if (op_i.apply && popped) begin
        count_q  <= cnt_pop;
        refill_q <= do_refill;
        if (!do_refill) begin
          top_q <= '0;
        end
      end
    end
  end

  assign count_o = count_q;
  assign top_o   = refill_q ? rd_q : top_q;

endmodule

// File: sv/pushdown_automaton_engine.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   pae_in_t  (slot write, symbol, end marker)
// res_o     out  valid/ready   pae_out_t (one trace record per event)
// cfg       in   cfg_we_i      cfg_idx_i selects register, cfg_data_i value
//
// Each move scans the current state's slots through the table memory, one read
// per cycle, until a slot matches or the last slot misses. Epsilon chains repeat
// the scan per move.
// Reset clears control, the slot valid bits and the stack count; no sweep.
// A stalled result port holds the sequencer at its next record.

module pushdown_automaton_engine #(
  parameter int MAX_EPS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pae_in_if.sink                           in_i,
  pae_out_if.source                        res_o,
  input  logic                             cfg_we_i,
  input  logic [pae_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pae_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pae_pkg::*;

  localparam int TBL_DEPTH = STATE_COUNT * SLOTS_PER_STATE;
  localparam int TAW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int IW  = $clog2(SLOTS_PER_STATE + 1);
  localparam int EW  = $clog2(MAX_EPS + 1);
  localparam int CW  = $clog2(STACK_SIZE + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_MOVE,
    ST_STUCK,
    ST_FINAL
  } state_e;

  state_e            state_q, state_d;
  logic [ST_W-1:0]   start_q;
  logic [MASK_W-1:0] mask_q;
  logic [ST_W-1:0]   cur_q, cur_d;
  logic [ST_W-1:0]   from_q, from_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic              seen_q, seen_d;
  logic              stuck_q, stuck_d;
  logic              end_q, end_d;
  logic              ok_q, ok_d;
  logic [EW-1:0]     eps_q, eps_d;
  logic [IW-1:0]     issue_q, issue_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic              out_valid_q, out_valid_d;
  pae_out_t          out_q, out_d;

  logic              tbl_wr_en;
  logic [TAW-1:0]    tbl_wr_addr;
  pae_entry_t        tbl_wr_data;
  logic              tbl_rd_en;
  logic [TAW-1:0]    tbl_rd_addr;
  pae_entry_t        entry;
  pae_stack_op_t     stk_op;
  logic [CW-1:0]     stk_count;
  logic [SYM_W-1:0]  stk_top;
  logic              stk_overflow;
  logic              hit;
  logic              is_eps;
  logic              emit_ok;
  logic [DEPTH_W-1:0] depth;

  pae_table #(.DEPTH(TBL_DEPTH), .AW(TAW)) u_pae_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (tbl_rd_addr),
    .rd_data_o (entry)
  );

  pae_stack #(.DEPTH(STACK_SIZE), .CW(CW)) u_pae_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (stk_op),
    .count_o    (stk_count),
    .top_o      (stk_top),
    .overflow_o (stk_overflow)
  );

  // Slot write from the input transaction
  assign tbl_wr_addr = TAW'(in_i.data.entry_state) * TAW'(SLOTS_PER_STATE)
                       + TAW'(in_i.data.entry_slot);
  assign tbl_wr_data.valid         = in_i.data.entry_valid;
  assign tbl_wr_data.slot.rd_sym   = in_i.data.entry_read;
  assign tbl_wr_data.slot.pop_sym  = in_i.data.entry_pop;
  assign tbl_wr_data.slot.push_sym = in_i.data.entry_push;
  assign tbl_wr_data.slot.nxt      = in_i.data.entry_next;
  assign tbl_rd_addr = TAW'(cur_q) * TAW'(SLOTS_PER_STATE) + TAW'(issue_q);

  // Match test on the slot just read
  assign is_eps = (entry.slot.rd_sym == '0);
  assign hit = entry.valid
               && (is_eps || entry.slot.rd_sym == sym_q)
               && (entry.slot.pop_sym == '0 || stk_count == '0
                   || entry.slot.pop_sym == stk_top);
  assign emit_ok = !out_valid_q || res_o.ready;
  assign depth   = DEPTH_W'(stk_count);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    from_d      = from_q;
    sym_d       = sym_q;
    seen_d      = seen_q;
    stuck_d     = stuck_q;
    end_d       = end_q;
    ok_d        = ok_q;
    eps_d       = eps_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    tbl_wr_en   = 1'b0;
    tbl_rd_en   = 1'b0;
    stk_op.clear    = 1'b0;
    stk_op.apply    = 1'b0;
    stk_op.pop_sym  = entry.slot.pop_sym;
    stk_op.push_sym = entry.slot.push_sym;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          unique case (kind_e'(in_i.data.kind))
            KIND_WRITE: begin
              tbl_wr_en = (32'(in_i.data.entry_state) < STATE_COUNT)
                          && (32'(in_i.data.entry_slot) < SLOTS_PER_STATE);
            end
            KIND_SYMBOL: begin
              sym_d = in_i.data.symbol;
              end_d = 1'b0;
              eps_d = '0;
              if (!seen_q) begin
                cur_d        = start_q;
                stk_op.clear = 1'b1;
                stuck_d      = 1'b0;
                seen_d       = 1'b1;
              end
              state_d = ST_START;
            end
            KIND_END: begin
              sym_d  = '0;
              end_d  = 1'b1;
              seen_d = 1'b0;
              if (!seen_q) begin
                cur_d        = start_q;
                stk_op.clear = 1'b1;
                stuck_d      = 1'b0;
                ok_d         = mask_q[start_q];
                state_d      = ST_FINAL;
              end else if (stuck_q) begin
                ok_d    = 1'b0;
                state_d = ST_FINAL;
              end else begin
                state_d = ST_START;
              end
            end
            KIND_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      ST_START: begin
        issue_d     = '0;
        pend_d      = 1'b0;
        pend_last_d = 1'b0;
        if (stuck_q) begin
          state_d = ST_STUCK;
        end else if (32'(cur_q) >= STATE_COUNT) begin
          // State without slots: no match
          if (end_q) begin
            ok_d    = 1'b0;
            state_d = ST_FINAL;
          end else begin
            stuck_d = 1'b1;
            state_d = ST_STUCK;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (pend_q && hit) begin
          if (!end_q && is_eps && eps_q >= EW'(MAX_EPS)) begin
            stuck_d = 1'b1;
            state_d = ST_STUCK;
          end else if (stk_overflow) begin
            if (end_q) begin
              ok_d    = 1'b0;
              state_d = ST_FINAL;
            end else begin
              stuck_d = 1'b1;
              state_d = ST_STUCK;
            end
          end else begin
            stk_op.apply = 1'b1;
            from_d       = cur_q;
            cur_d        = entry.slot.nxt;
            if (is_eps && !end_q) begin
              eps_d = eps_q + EW'(1);
            end
            state_d = ST_MOVE;
          end
        end else if (pend_q && pend_last_q) begin
          if (end_q) begin
            ok_d    = 1'b0;
            state_d = ST_FINAL;
          end else begin
            stuck_d = 1'b1;
            state_d = ST_STUCK;
          end
        end else begin
          // Issue the next slot read
          tbl_rd_en   = 1'b1;
          pend_d      = 1'b1;
          pend_last_d = (issue_q == IW'(SLOTS_PER_STATE - 1));
          issue_d     = issue_q + IW'(1);
        end
      end

      ST_MOVE: begin
        if (emit_ok) begin
          out_valid_d     = 1'b1;
          out_d.event_res = EV_MOVE;
          out_d.from_state = from_q;
          out_d.read_sym  = entry.slot.rd_sym;
          out_d.pop_sym   = entry.slot.pop_sym;
          out_d.push_sym  = entry.slot.push_sym;
          out_d.to_state  = cur_q;
          out_d.depth     = depth;
          out_d.top_sym   = stk_top;
          out_d.last      = !end_q && !is_eps;
          if (end_q) begin
            ok_d    = mask_q[cur_q];
            state_d = ST_FINAL;
          end else if (is_eps) begin
            state_d = ST_START;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_STUCK: begin
        if (emit_ok) begin
          out_valid_d      = 1'b1;
          out_d.event_res  = EV_STUCK;
          out_d.from_state = cur_q;
          out_d.read_sym   = sym_q;
          out_d.pop_sym    = '0;
          out_d.push_sym   = '0;
          out_d.to_state   = cur_q;
          out_d.depth      = depth;
          out_d.top_sym    = stk_top;
          out_d.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      ST_FINAL: begin
        if (emit_ok) begin
          out_valid_d      = 1'b1;
          out_d.event_res  = ok_q ? EV_ACCEPT : EV_REJECT;
          out_d.from_state = cur_q;
          out_d.read_sym   = '0;
          out_d.pop_sym    = '0;
          out_d.push_sym   = '0;
          out_d.to_state   = cur_q;
          out_d.depth      = depth;
          out_d.top_sym    = stk_top;
          out_d.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      from_q      <= '0;
      sym_q       <= '0;
      seen_q      <= 1'b0;
      stuck_q     <= 1'b0;
      end_q       <= 1'b0;
      ok_q        <= 1'b0;
      eps_q       <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      from_q      <= from_d;
      sym_q       <= sym_d;
      seen_q      <= seen_d;
      stuck_q     <= stuck_d;
      end_q       <= end_d;
      ok_q        <= ok_d;
      eps_q       <= eps_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      mask_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_STATE: start_q <= cfg_data_i[ST_W-1:0];
        CFG_ACCEPT_MASK: mask_q  <= cfg_data_i[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/pae_chk.sv
`timescale 1ns / 1ps

module pae_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [1:0]        in_kind_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input pae_pkg::pae_out_t res_data_i
);
  import pae_pkg::*;

  logic in_acc;
  logic res_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign res_acc = res_valid_i && res_ready_i;

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  // Symbol and end transactions keep the input closed while they work
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_kind_i == KIND_SYMBOL || in_kind_i == KIND_END) |=> !in_ready_i)
    else $error("input reopened during a string step");

  // Writes and unused kinds produce no record
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_kind_i == KIND_WRITE || in_kind_i == KIND_NONE)
    |=> !$rose(res_valid_i))
    else $error("record produced by a silent transaction");

  // Non-move records end the item and keep the state
  a_terminal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_acc && res_data_i.event_res != EV_MOVE
    |-> res_data_i.last && res_data_i.from_state == res_data_i.to_state)
    else $error("terminal record malformed");

endmodule

bind pushdown_automaton_engine pae_chk u_pae_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.data.kind),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
